// ===== rtl/pink_noise_filter_unit_defines.svh =====
// Assertion macros shared by the pink noise filter RTL.
`ifndef PINK_NOISE_FILTER_UNIT_DEFINES_SVH
`define PINK_NOISE_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define PNF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define PNF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pnf_pkg.sv =====
// Shared constants, types and coefficient tables of the pink noise filter.
`default_nettype none

package pnf_pkg;

    // Field and state widths
    localparam int SAMPLE_W = 16;
    localparam int STATE_W  = 32;
    localparam int FRAC_W   = 24;
    localparam int SECTIONS = 6;

    // Running sum of sections holds a few guard bits over the state width
    localparam int SUM_W    = STATE_W + 4;
    localparam int MAG_W    = SUM_W;

    // Serial multiplier: coefficient consumed one digit per cycle
    localparam int DIGIT_W  = 4;
    localparam int COEF_W   = FRAC_W;
    localparam int DIGITS   = COEF_W / DIGIT_W;
    localparam int DIG_W    = $clog2(DIGITS);
    localparam int ACC_W    = MAG_W + DIGIT_W;

    // Sample to Q.24 alignment and output rounding
    localparam int WIDEN_SH   = FRAC_W + 1 - SAMPLE_W;
    localparam int ROUND_HALF = 1 << (WIDEN_SH - 1);
    localparam int SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;

    // Product sequence: pole/gain pair per section, then direct, hold, scale
    localparam int OPS  = 2 * SECTIONS + 3;
    localparam int OP_W = $clog2(OPS);

    typedef logic [OP_W-1:0]  op_t;
    typedef logic [DIG_W-1:0] dig_t;

    localparam op_t  OP_FIRST  = '0;
    localparam op_t  OP_DIRECT = op_t'(2 * SECTIONS);
    localparam op_t  OP_HOLD   = op_t'(2 * SECTIONS + 1);
    localparam op_t  OP_SCALE  = op_t'(2 * SECTIONS + 2);
    localparam dig_t DIG_LAST  = dig_t'(DIGITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_POST = 3'b100
    } state_t;

    // Coefficient magnitudes in Q.24, in product order
    localparam logic [COEF_W-1:0] COEF_MAG [OPS] = '{
        24'd16758090, 24'd931436,
        24'd16665144, 24'd1259565,
        24'd16257122, 24'd2581208,
        24'd14537458, 24'd5209084,
        24'd9227469,  24'd8941454,
        24'd12777528, 24'd283501,
        24'd8995943,
        24'd1944916,
        24'd1845494
    };

    // Coefficient signs: only the last section's pole and gain are negative
    localparam logic [OPS-1:0] COEF_NEG = 15'b000110000000000;

endpackage

`default_nettype wire

// ===== rtl/pnf_white_if.sv =====
// Input channel carrying white noise samples.
`default_nettype none

interface pnf_white_if import pnf_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] white_sample;

    modport source (output valid, output white_sample, input ready);
    modport sink   (input valid, input white_sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/pnf_pink_if.sv =====
// Output channel carrying pink filtered samples.
`default_nettype none

interface pnf_pink_if import pnf_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] pink_sample;

    modport source (output valid, output pink_sample, input ready);
    modport sink   (input valid, input pink_sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/pink_noise_filter_unit.sv =====
// Pink noise shaping filter: six one-pole sections on a digit-serial multiplier.
`default_nettype none
`include "pink_noise_filter_unit_defines.svh"

// Takes one signed Q1.15 white noise word and returns one Q1.15 pink word,
// rounded and saturated. State (six Q8.24 sections and the held white term)
// comes out of reset as zero. All fifteen coefficient products of a sample
// run through one shared multiplier that takes the 24-bit coefficient four
// bits per cycle, each product followed by a step that folds it into the
// state. The next word is accepted only after the result of the previous
// one has been written to the output register, so the filter works on one
// word at a time. The output register holds the result until it is taken
// while the filter already works on the next word; if the previous result
// is still waiting when a new one is ready, the filter holds in its last
// step until the output register frees up.
module pink_noise_filter_unit import pnf_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pnf_white_if.sink  white,
    pnf_pink_if.source pink
);

    // Saturate a wide signed value to the state width
    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [SUM_W-1:0] v
    );
        logic [SUM_W-STATE_W:0] hi_bits;
        hi_bits = v[SUM_W-1:STATE_W-1];
        if (&hi_bits || ~|hi_bits)
            return v[STATE_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(STATE_W-1){1'b0}}};
        else
            return {1'b0, {(STATE_W-1){1'b1}}};
    endfunction

    // Magnitude of a signed operand
    function automatic logic [MAG_W-1:0] mag_of(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] neg_v;
        neg_v = -v;
        return v[SUM_W-1] ? MAG_W'(neg_v) : MAG_W'(v);
    endfunction

    // Control
    state_t                     state_reg, state_next;
    op_t                        op_reg, op_next;
    dig_t                       dig_reg, dig_next;
    logic                       pink_valid_reg, pink_valid_next;

    // Filter state
    logic signed [STATE_W-1:0]  sec_reg [SECTIONS];
    logic signed [STATE_W-1:0]  sec_next [SECTIONS];
    logic signed [STATE_W-1:0]  held_reg, held_next;

    // Per-sample working registers
    logic signed [SAMPLE_W-1:0] white_reg, white_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [SUM_W-1:0]    part_reg, part_next;
    logic signed [SAMPLE_W-1:0] pink_reg, pink_next;

    // Serial multiplier
    logic [MAG_W-1:0]           a_reg, a_next;
    logic [COEF_W-1:0]          c_reg, c_next;
    logic [MAG_W-1:0]           acc_reg, acc_next;
    logic                       rnd_reg, rnd_next;
    logic                       neg_reg, neg_next;

    logic signed [FRAC_W:0]     white_q;
    logic signed [SUM_W-1:0]    white_w;
    logic [ACC_W-1:0]           acc_sum;
    logic [MAG_W:0]             prod_mag;
    logic signed [MAG_W+1:0]    prod_pos;
    logic signed [MAG_W+1:0]    prod_wide;
    logic signed [SUM_W-1:0]    prod;
    logic signed [SUM_W-1:0]    sec_sum;
    logic signed [STATE_W-1:0]  sec_sat;
    logic [MAG_W:0]             round_mag;
    logic [SAMPLE_W-1:0]        y;
    op_t                        op_inc;
    logic signed [SUM_W-1:0]    next_operand;
    logic                       load;
    op_t                        ld_op;
    logic signed [SUM_W-1:0]    ld_val;

    // Sample widened to Q.24
    assign white_q = {white_reg, {WIDEN_SH{1'b0}}};
    assign white_w = SUM_W'(white_q);

    // One multiplier digit: partial sum plus multiplicand times digit
    assign acc_sum = ACC_W'(acc_reg) + ACC_W'(a_reg) * ACC_W'(c_reg[DIGIT_W-1:0]);

    // Finished product, rounded half away from zero on the magnitude
    assign prod_mag  = {1'b0, acc_reg} + (MAG_W+1)'(rnd_reg);
    assign prod_pos  = signed'({1'b0, prod_mag});
    assign prod_wide = neg_reg ? -prod_pos : prod_pos;
    assign prod      = prod_wide[SUM_W-1:0];

    // New section value
    assign sec_sum = part_reg + prod;
    assign sec_sat = sat_state(sec_sum);

    // Output word: drop the extra fraction bits, round, saturate
    assign round_mag = (prod_mag + (MAG_W+1)'(ROUND_HALF)) >> WIDEN_SH;
    always_comb
    begin
        if (!neg_reg)
        begin
            if (round_mag > (MAG_W+1)'(SAMPLE_MAX))
                y = {1'b0, {(SAMPLE_W-1){1'b1}}};
            else
                y = round_mag[SAMPLE_W-1:0];
        end
        else
        begin
            if (round_mag > (MAG_W+1)'(SAMPLE_MAX + 1))
                y = {1'b1, {(SAMPLE_W-1){1'b0}}};
            else
                y = '0 - round_mag[SAMPLE_W-1:0];
        end
    end

    // Operand of the following product; a pole product after a gain product
    // reads the section that rotates into the head slot
    assign op_inc = op_reg + 1'b1;
    always_comb
    begin
        priority if (op_inc == OP_SCALE)
            next_operand = sum_reg;
        else if (op_inc < OP_DIRECT && !op_inc[0])
            next_operand = SUM_W'(sec_reg[1]);
        else
            next_operand = white_w;
    end

    // Sequencer and datapath
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        dig_next        = dig_reg;
        pink_valid_next = pink_valid_reg;
        sec_next        = sec_reg;
        held_next       = held_reg;
        white_next      = white_reg;
        sum_next        = sum_reg;
        part_next       = part_reg;
        pink_next       = pink_reg;
        a_next          = a_reg;
        c_next          = c_reg;
        acc_next        = acc_reg;
        rnd_next        = rnd_reg;
        neg_next        = neg_reg;
        load            = 1'b0;
        ld_op           = op_inc;
        ld_val          = next_operand;

        // Output word taken
        if (pink_valid_reg && pink.ready)
            pink_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (white.valid)
                begin
                    white_next = white.white_sample;
                    sum_next   = '0;
                    op_next    = OP_FIRST;
                    load       = 1'b1;
                    ld_op      = OP_FIRST;
                    ld_val     = SUM_W'(sec_reg[0]);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                acc_next = acc_sum[ACC_W-1:DIGIT_W];
                rnd_next = acc_sum[DIGIT_W-1];
                c_next   = c_reg >> DIGIT_W;
                dig_next = dig_reg + 1'b1;
                if (dig_reg == DIG_LAST)
                    state_next = ST_POST;
            end
            ST_POST:
            begin
                if (op_reg == OP_SCALE)
                begin
                    // Last product: wait for a free output register
                    if (!pink_valid_reg || pink.ready)
                    begin
                        pink_next       = signed'(y);
                        pink_valid_next = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    priority if (op_reg == OP_HOLD)
                        held_next = sat_state(prod);
                    else if (op_reg == OP_DIRECT)
                        sum_next = sum_reg + SUM_W'(held_reg) + prod;
                    else if (op_reg[0])
                    begin
                        // Gain product closes a section; rotate the ring
                        for (int j = 0; j < SECTIONS - 1; j++)
                            sec_next[j] = sec_reg[j+1];
                        sec_next[SECTIONS-1] = sec_sat;
                        sum_next = sum_reg + SUM_W'(sec_sat);
                    end
                    else
                        part_next = prod;
                    op_next    = op_inc;
                    load       = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Set up the multiplier for the next product
        if (load)
        begin
            a_next   = mag_of(ld_val);
            neg_next = ld_val[SUM_W-1] ^ COEF_NEG[ld_op];
            c_next   = COEF_MAG[ld_op];
            acc_next = '0;
            rnd_next = 1'b0;
            dig_next = '0;
        end
    end

    // Control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_FIRST;
            dig_reg        <= '0;
            pink_valid_reg <= 1'b0;
            held_reg       <= '0;
            for (int j = 0; j < SECTIONS; j++)
                sec_reg[j] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            dig_reg        <= dig_next;
            pink_valid_reg <= pink_valid_next;
            held_reg       <= held_next;
            sec_reg        <= sec_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        white_reg <= white_next;
        sum_reg   <= sum_next;
        part_reg  <= part_next;
        pink_reg  <= pink_next;
        a_reg     <= a_next;
        c_reg     <= c_next;
        acc_reg   <= acc_next;
        rnd_reg   <= rnd_next;
        neg_reg   <= neg_next;
    end

    assign white.ready      = (state_reg == ST_IDLE);
    assign pink.valid       = pink_valid_reg;
    assign pink.pink_sample = pink_reg;

    // Checks
    `PNF_ASSERT_NEXT(a_accept_starts_first, white.valid && white.ready,
        state_reg == ST_RUN && op_reg == OP_FIRST && dig_reg == '0,
        "accepted word did not start the first product")
    `PNF_ASSERT_NEXT(a_run_ends_in_post, state_reg == ST_RUN && dig_reg == DIG_LAST,
        state_reg == ST_POST, "multiplier did not finish after the last digit")
    `PNF_ASSERT_NOW(a_coef_consumed, state_reg == ST_POST, c_reg == '0,
        "product used before all coefficient digits were consumed")
    `PNF_ASSERT_NOW(a_result_from_scale, $rose(pink_valid_reg),
        $past(state_reg == ST_POST && op_reg == OP_SCALE),
        "output word raised outside the final scaling step")

endmodule

`default_nettype wire

// ===== tb/sv/tb_pink_noise_filter_unit.sv =====
// Self-checking testbench for the pink noise filter: directed and random words, both sides stalled.
`default_nettype none

module tb_pink_noise_filter_unit;
    import pnf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum int {
        SEG_UNIFORM,
        SEG_POS_FULL,
        SEG_NEG_FULL,
        SEG_SMALL,
        SEG_ALTERNATE
    } segment_t;

    localparam int     RANDOM_WORDS = 1250;
    localparam int     HOLD_AT      = 100;
    localparam int     HOLD_CYCLES  = 600;
    localparam int     DRAIN_CYCLES = 120;
    localparam longint CYCLE_LIMIT  = 1500000;

    // Q.24 filter coefficients, signed
    localparam longint POLE_Q24 [SECTIONS] = '{
        16758090, 16665144, 16257122, 14537458, 9227469, -12777528
    };
    localparam longint GAIN_Q24 [SECTIONS] = '{
        931436, 1259565, 2581208, 5209084, 8941454, -283501
    };
    localparam longint DIRECT_Q24 = 8995943;
    localparam longint HOLD_Q24   = 1944916;
    localparam longint SCALE_Q24  = 1845494;

    // Filter model and queue of expected pink words
    class pink_tracker;
        longint  sections [SECTIONS];
        longint  held_term;
        sample_t expected_pink [$];
        int      errors;
        int      words_taken;

        function new();
            foreach (sections[i])
                sections[i] = 0;
            held_term   = 0;
            errors      = 0;
            words_taken = 0;
        endfunction

        // Coefficient product back to Q.24, round half away from zero
        function automatic longint mul_q24(longint a, longint c);
            bit                neg;
            longint unsigned   ma;
            longint unsigned   mc;
            longint unsigned   hi;
            longint unsigned   lo;
            longint unsigned   r;
            neg = (a < 0) != (c < 0);
            ma  = (a < 0) ? longint'(-a) : longint'(a);
            mc  = (c < 0) ? longint'(-c) : longint'(c);
            hi  = ma >> FRAC_W;
            lo  = ma & ((64'd1 << FRAC_W) - 64'd1);
            r   = hi * mc + ((lo * mc + (64'd1 << (FRAC_W - 1))) >> FRAC_W);
            return neg ? -longint'(r) : longint'(r);
        endfunction

        function automatic longint clamp(longint v, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        // One filter step on an accepted white word
        function automatic sample_t filter_step(sample_t w);
            longint          white;
            longint          sum;
            longint          scaled;
            longint unsigned mag;
            longint          rounded;
            white = longint'(w) * (longint'(1) <<< WIDEN_SH);
            sum   = 0;
            for (int i = 0; i < SECTIONS; i++)
            begin
                sections[i] = clamp(mul_q24(sections[i], POLE_Q24[i]) +
                                    mul_q24(white, GAIN_Q24[i]), STATE_W);
                sum += sections[i];
            end
            sum += held_term;
            sum += mul_q24(white, DIRECT_Q24);
            scaled = mul_q24(sum, SCALE_Q24);
            // Q.24 back to sample scale, round half away from zero
            mag     = (scaled < 0) ? longint'(-scaled) : longint'(scaled);
            mag     = (mag + (64'd1 << (WIDEN_SH - 1))) >> WIDEN_SH;
            rounded = (scaled < 0) ? -longint'(mag) : longint'(mag);
            held_term = clamp(mul_q24(white, HOLD_Q24), STATE_W);
            return sample_t'(clamp(rounded, SAMPLE_W));
        endfunction

        function void note_white(sample_t w);
            expected_pink.push_back(filter_step(w));
        endfunction

        function void check_pink(sample_t actual);
            sample_t want;
            words_taken++;
            if (expected_pink.size() == 0)
            begin
                $error("pink_sample unexpected: actual %0d", actual);
                errors++;
            end
            else
            begin
                want = expected_pink.pop_front();
                if (actual !== want)
                begin
                    $error("pink_sample mismatch: expected %0d, actual %0d", want, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_pink.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    longint      cycles;
    pink_tracker tracker;

    pnf_white_if white_bus ();
    pnf_pink_if  pink_bus ();

    pink_noise_filter_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .white (white_bus),
        .pink  (pink_bus)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle count and timeout
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_pink_noise_filter_unit: FAIL");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(30, 120);
    endfunction

    // Offer one white word after a random gap, wait for it to be taken
    task automatic send_white(input sample_t w);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            white_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        white_bus.valid        <= 1'b1;
        white_bus.white_sample <= w;
        do
            @(posedge clk);
        while (!white_bus.ready);
        tracker.note_white(w);
    endtask

    task automatic wait_drained();
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // Extremes, bit patterns, a positive full-scale run into saturation, then negative
    task automatic run_directed();
        sample_t pattern [5];
        pattern = '{16'sd0, 16'sd1, -16'sd1, 16'h5555, 16'hAAAA};
        foreach (pattern[i])
            send_white(pattern[i]);
        repeat (14) send_white(sample_t'(SAMPLE_MAX));
        repeat (6) send_white(sample_t'(-SAMPLE_MAX - 1));
    endtask

    // Random segments: uniform noise, full-scale runs, small values, alternating extremes
    task automatic run_random();
        int       left;
        int       len;
        bit       flip;
        segment_t kind;
        left = RANDOM_WORDS;
        while (left > 0)
        begin
            kind = segment_t'($urandom_range(0, 4));
            if (kind == SEG_POS_FULL || kind == SEG_NEG_FULL)
                len = $urandom_range(20, 90);
            else
                len = $urandom_range(10, 60);
            if (len > left)
                len = left;
            flip = $urandom_range(0, 1);
            for (int i = 0; i < len; i++)
            begin
                case (kind)
                    SEG_UNIFORM:  send_white(sample_t'($urandom()));
                    SEG_POS_FULL: send_white(sample_t'(SAMPLE_MAX));
                    SEG_NEG_FULL: send_white(sample_t'(-SAMPLE_MAX - 1));
                    SEG_SMALL:    send_white(sample_t'(int'($urandom_range(0, 511)) - 256));
                    default:
                    begin
                        send_white(flip ? sample_t'(SAMPLE_MAX) : sample_t'(-SAMPLE_MAX - 1));
                        flip = !flip;
                    end
                endcase
            end
            left -= len;
        end
    endtask

    // Result side: random stalls, calm stretches, one long hold-off
    initial
    begin : pink_sink
        int idle_left;
        bit calm;
        bit hold_done;
        idle_left = 0;
        calm      = 1'b0;
        hold_done = 1'b0;
        pink_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!hold_done && tracker.words_taken == HOLD_AT)
            begin
                idle_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if ((cycles % 1000) == 0 && $urandom_range(0, 3) == 0)
                calm = !calm;
            if (idle_left > 0)
            begin
                pink_bus.ready <= 1'b0;
                idle_left--;
            end
            else
            begin
                pink_bus.ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 8)
                    idle_left = idle_gap();
            end
            @(posedge clk);
            if (pink_bus.valid && pink_bus.ready)
                tracker.check_pink(pink_bus.pink_sample);
        end
    end

    // Reset, stimulus, drain, verdict
    initial
    begin : main_flow
        int drain;
        tracker = new();
        rst_n                  <= 1'b0;
        white_bus.valid        <= 1'b0;
        white_bus.white_sample <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        white_bus.valid <= 1'b0;
        wait_drained();
        run_random();
        white_bus.valid <= 1'b0;

        wait_drained();
        drain = 0;
        while (drain < DRAIN_CYCLES)
        begin
            @(posedge clk);
            drain++;
        end
        if (tracker.pending() != 0)
        begin
            $error("pink_sample missing: %0d words still expected", tracker.pending());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("tb_pink_noise_filter_unit: PASS");
        else
            $display("tb_pink_noise_filter_unit: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
